### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the mouse packet tracker.
// Standalone header; it relies on no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define PMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked only while out of reset.
`define PMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/pmt_pkg.sv
// Shared types and constants of the mouse packet tracker.
// Used by the front, the back and the top level; depends on nothing.
package pmt_pkg;

  // Width of the configuration data and of the screen limits.
  localparam int CFG_W = 15;
  // Width of the signed position sum; leaves room for carry and sign.
  localparam int SUM_W = CFG_W + 2;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLAMP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] WIDTH_RST  = 15'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 15'd768;

  // Status byte bits that flag an X or Y overflow.
  localparam logic [7:0] STATUS_OVF_MASK = 8'hC0;
  localparam int STATUS_SIGN_X = 4;
  localparam int STATUS_SIGN_Y = 5;

  // Position of the next byte within a packet.
  typedef enum logic [1:0] {
    SLOT_STATUS = 2'd0,
    SLOT_XDELTA = 2'd1,
    SLOT_YDELTA = 2'd2
  } slot_t;

  // A complete, non-overflow packet handed from front to back.
  typedef struct packed {
    logic       sign_x;
    logic       sign_y;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  // Configuration as seen by the position unit.
  typedef struct packed {
    logic             clamp;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } cfg_t;

endpackage

### hw/rtl/pmt_fifo.sv
// Small first-in first-out queue with a show-ahead read port.
// Generic; used between front and back and on the result side.
module pmt_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  // DEPTH must be a power of two so that the pointers wrap by themselves.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hw/rtl/pmt_front.sv
// Front part: gathers mouse bytes into packets and drops overflow packets.
// Depends on pmt_pkg for the slot type and the packet struct.
module pmt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_valid,
  input  logic [7:0]    data_byte,
  output logic          pkt_push,
  output pmt_pkg::pkt_t pkt_data,
  output logic [1:0]    slot
);
  import pmt_pkg::*;

  slot_t      slot_r, slot_nxt;
  logic [7:0] status_r, xdelta_r;
  logic       take_status, take_xdelta, take_ydelta;

  assign slot = slot_r;

  // Next slot: the packet framing is purely positional.
  always_comb begin
    slot_nxt = slot_r;
    if (byte_valid) begin
      unique case (slot_r)
        SLOT_STATUS: slot_nxt = SLOT_XDELTA;
        SLOT_XDELTA: slot_nxt = SLOT_YDELTA;
        default:     slot_nxt = SLOT_STATUS;
      endcase
    end
  end

  // Outputs of the slot machine: which byte is captured, and the packet push.
  always_comb begin
    take_status = 1'b0;
    take_xdelta = 1'b0;
    take_ydelta = 1'b0;
    unique case (slot_r)
      SLOT_STATUS: take_status = byte_valid;
      SLOT_XDELTA: take_xdelta = byte_valid;
      default:     take_ydelta = byte_valid;
    endcase
  end

  assign pkt_push        = take_ydelta && ((status_r & STATUS_OVF_MASK) == 8'h00);
  assign pkt_data.sign_x = status_r[STATUS_SIGN_X];
  assign pkt_data.sign_y = status_r[STATUS_SIGN_Y];
  assign pkt_data.dx     = xdelta_r;
  assign pkt_data.dy     = data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= SLOT_STATUS;
      status_r <= '0;
      xdelta_r <= '0;
    end else begin
      slot_r <= slot_nxt;
      if (take_status) begin
        status_r <= data_byte;
      end
      if (take_xdelta) begin
        xdelta_r <= data_byte;
      end
    end
  end

endmodule

### hw/rtl/pmt_back.sv
// Back part: applies packet deltas to the cursor position with saturation.
// Depends on pmt_pkg for the packet and configuration structs.
module pmt_back #(
  parameter int COORD_BITS = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pmt_pkg::cfg_t         cfg,
  input  logic                  pkt_empty,
  input  pmt_pkg::pkt_t         pkt_data,
  output logic                  pkt_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [COORD_BITS-1:0] res_x,
  output logic [COORD_BITS-1:0] res_y
);
  import pmt_pkg::*;

  localparam logic [CFG_W-1:0] COORD_MAX = CFG_W'((1 << COORD_BITS) - 1);

  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r, pos_y_nxt;
  logic signed [SUM_W-1:0] dx_ext, dy_ext, sum_x, sum_y;
  logic [CFG_W-1:0] top_x, top_y;
  logic [CFG_W-1:0] sat_x, sat_y;
  logic fire;

  // Clip a signed sum into the range zero to top.
  function automatic logic [CFG_W-1:0] sat_axis(input logic signed [SUM_W-1:0] v,
                                                input logic [CFG_W-1:0] top);
    logic [CFG_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, top})) begin
      res = top;
    end else begin
      res = v[CFG_W-1:0];
    end
    return res;
  endfunction

  // One packet is retired per cycle while there is room for the result.
  assign fire     = !pkt_empty && !res_full;
  assign pkt_pop  = fire;
  assign res_push = fire;

  // Nine-bit deltas; Y is negated so that it grows downward.
  always_comb begin
    dx_ext = {{(SUM_W-8){pkt_data.sign_x}}, pkt_data.dx};
    dy_ext = -$signed({{(SUM_W-8){pkt_data.sign_y}}, pkt_data.dy});
    sum_x  = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_x_r}) + dx_ext;
    sum_y  = $signed({{(SUM_W-COORD_BITS){1'b0}}, pos_y_r}) + dy_ext;
    top_x  = (cfg.clamp && (cfg.width < COORD_MAX)) ? cfg.width : COORD_MAX;
    top_y  = (cfg.clamp && (cfg.height < COORD_MAX)) ? cfg.height : COORD_MAX;
  end

  assign sat_x     = sat_axis(sum_x, top_x);
  assign sat_y     = sat_axis(sum_y, top_y);
  assign pos_x_nxt = sat_x[COORD_BITS-1:0];
  assign pos_y_nxt = sat_y[COORD_BITS-1:0];
  assign res_x     = pos_x_nxt;
  assign res_y     = pos_y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
    end else if (fire) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

endmodule

### hw/rtl/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker, top level.
// Byte stream in, cursor position out. Uses pmt_pkg, pmt_front, pmt_fifo,
// pmt_back and assert_macros.svh.
//
// Input channel: one mouse byte per beat on in_data_byte, taken when
// in_push is high and in_full is low. Bytes group into three-byte packets
// purely by position (status, X delta, Y delta); there is no resync.
// Result channel: after each packet without overflow flags one beat with
// the new cursor position appears; it waits while out_empty is low and
// leaves at an edge where out_pop is high. Overflow packets give no beat.
// Configuration: cfg_index/cfg_data beats, always ready, one register per
// beat (0 clamp enable, 1 screen width, 2 screen height); index 3 is ignored.
// Throughput: one byte per cycle while in_full is low. A packet is written
// into the packet queue as its third byte is taken; the position unit
// computes from the head of that queue and writes the new position into
// the result queue, from which it can be popped.
// Stalls: if out_pop stays low, the two-entry result queue and then the
// two-entry packet queue fill, and in_full rises until a result leaves.
// Reset (synchronous, rst_n low) empties both queues, restarts framing at
// the status byte, sets the cursor to the origin and the registers to
// clamp off, width 1024, height 768.
`include "assert_macros.svh"

module ps2_mouse_packet_tracker #(
  parameter int COORD_BITS = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [COORD_BITS-1:0]          out_cursor_x,
  output logic [COORD_BITS-1:0]          out_cursor_y,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmt_pkg::CFG_W-1:0]      cfg_data
);
  import pmt_pkg::*;

  localparam int PKT_W = $bits(pkt_t);
  localparam int RES_W = 2 * COORD_BITS;

  cfg_t cfg_r;
  logic in_beat, cfg_beat;
  logic pkt_push, pkt_full, pkt_pop, pkt_empty;
  pkt_t pkt_wdata, pkt_rdata;
  logic [PKT_W-1:0] pkt_rbits;
  logic [1:0] slot;
  logic res_push, res_full;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic [RES_W-1:0] res_rbits;

  assign cfg_ready = 1'b1;
  assign cfg_beat  = cfg_valid && cfg_ready;
  assign in_full   = pkt_full;
  assign in_beat   = in_push && !in_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clamp  <= 1'b0;
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
    end else if (cfg_beat) begin
      case (cfg_index)
        CFG_IDX_CLAMP:  cfg_r.clamp  <= cfg_data[0];
        CFG_IDX_WIDTH:  cfg_r.width  <= cfg_data;
        CFG_IDX_HEIGHT: cfg_r.height <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Packet framing and overflow filtering.
  pmt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_beat),
    .data_byte  (in_data_byte),
    .pkt_push   (pkt_push),
    .pkt_data   (pkt_wdata),
    .slot       (slot)
  );

  // Packet queue between front and back.
  pmt_fifo #(
    .WIDTH (PKT_W),
    .DEPTH (2)
  ) u_pkt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pkt_push),
    .wdata (pkt_wdata),
    .full  (pkt_full),
    .pop   (pkt_pop),
    .rdata (pkt_rbits),
    .empty (pkt_empty)
  );

  assign pkt_rdata = pkt_rbits;

  // Cursor update.
  pmt_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pkt_empty (pkt_empty),
    .pkt_data  (pkt_rdata),
    .pkt_pop   (pkt_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_x     (res_x),
    .res_y     (res_y)
  );

  // Result queue toward the consumer.
  pmt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_x, res_y}),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rbits),
    .empty (out_empty)
  );

  assign out_cursor_x = res_rbits[RES_W-1:COORD_BITS];
  assign out_cursor_y = res_rbits[COORD_BITS-1:0];

  // The front only completes a packet while the packet queue has room.
  `PMT_ASSERT_NOW(a_pkt_no_overrun, clk, rst_n, pkt_push, !pkt_full)
  // The back never writes a result into a full result queue.
  `PMT_ASSERT_NOW(a_res_no_overrun, clk, rst_n, res_push, !res_full)
  // With nothing queued and no byte arriving, no result may appear.
  `PMT_ASSERT_NEXT(a_no_phantom, clk, rst_n, !in_push && pkt_empty && out_empty, out_empty)
  // A byte taken at the status slot never produces a packet.
  `PMT_ASSERT_NOW(a_status_no_push, clk, rst_n, in_beat && (slot == SLOT_STATUS), !pkt_push)

endmodule
